### rtl/core/crsk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsk_pkg
// Shared types, constants and helpers for the cable robot step kinematics core.
// ----------------------------------------------------------------------------
package crsk_pkg;

	// fixed point format of positions, slopes and scale factors
	localparam int FRAC_BITS = 16;
	localparam int NUM_CABLES = 3;
	localparam int SQ_STEPS = 32;

	typedef logic signed [31:0] s32_t;
	typedef logic [7:0] cfg_idx_t;

	// configuration register indexes
	typedef enum logic [7:0] {
		REG_STEPS_PER_LENGTH = 8'd0,
		REG_STEPS_PER_ANGLE  = 8'd1,
		REG_ZERO_OFFSET      = 8'd2,
		REG_SLOPE_X          = 8'd3,
		REG_SLOPE_Y          = 8'd4,
		REG_SLOPE_Y_ABS      = 8'd5
	} cfg_reg_t;

	// effective anchor positions (post minus hook offset)
	localparam s32_t ANCHOR_X [NUM_CABLES] = '{
		32'sd0, 32'(48 * (2 ** FRAC_BITS)), 32'(24 * (2 ** FRAC_BITS))};
	localparam s32_t ANCHOR_Y [NUM_CABLES] = '{
		32'sd0, 32'sd0, 32'(40 * (2 ** FRAC_BITS))};
	localparam s32_t ANCHOR_Z [NUM_CABLES] = '{
		32'(60 * (2 ** FRAC_BITS)), 32'(60 * (2 ** FRAC_BITS)),
		32'(60 * (2 ** FRAC_BITS))};

	// largest length step count before the zero offset is applied
	localparam logic [63:0] STEP_CLAMP = 64'h0000_0001_FFFF_FFFC;

	// result fields carried alongside the cable math
	typedef struct packed {
		s32_t rot;
		logic mag;
	} side_t;

	// divide by 2^FRAC_BITS, truncating toward zero
	function automatic logic signed [64:0] tdiv_frac(input logic signed [64:0] p);
		logic signed [64:0] bias;
		bias = p[64] ? 65'((2 ** FRAC_BITS) - 1) : 65'sd0;
		return (p + bias) >>> FRAC_BITS;
	endfunction

	// saturate a wide signed value to 32 bits
	function automatic s32_t sat32(input logic signed [66:0] v);
		s32_t r;
		if (v > 67'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -67'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// magnitude limited to 2^31-1
	function automatic logic [30:0] mag_sat(input logic signed [32:0] d);
		logic [32:0] m;
		m = d[32] ? 33'(-d) : 33'(d);
		return (m > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : m[30:0];
	endfunction

endpackage

### rtl/core/crsk_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsk channel interfaces
// Pose input, step output and configuration write channels.
// ----------------------------------------------------------------------------
interface crsk_pose_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] angle;
	logic        magnet_in;
	modport source (output valid, pos_x, pos_y, pos_z, angle, magnet_in, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, angle, magnet_in, output ready);
endinterface

interface crsk_step_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] cable0_steps;
	logic signed [31:0] cable1_steps;
	logic signed [31:0] cable2_steps;
	logic signed [31:0] rotation_steps;
	logic        magnet_out;
	modport source (output valid, cable0_steps, cable1_steps, cable2_steps,
		rotation_steps, magnet_out, input ready);
	modport sink (input valid, cable0_steps, cable1_steps, cable2_steps,
		rotation_steps, magnet_out, output ready);
endinterface

interface crsk_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/cable_robot_step_kinematics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cable_robot_step_kinematics_core
// Inverse kinematics of a three cable robot: pose in, motor step targets out.
// ----------------------------------------------------------------------------
// Usage:
//   pose  - one word per target pose (x, y, z, angle in Q16.16, magnet bit)
//   steps - one word per pose: three cable step counts, rotation steps, magnet
//   cfg   - register writes (index, data), always ready; write only when idle
// The pipeline holds 40 register stages between pose input and steps output.
// The stages are six arithmetic
// stages (slope products, truncation, bed sum, distances, squares, sum of
// squares), 32 square root stages retiring one root bit each, then the
// length scale multiply and the offset/saturate output register.
// Throughput is one pose per cycle while no output word waits on the receiver;
// the stage registers move together. While a valid output word waits on the receiver the whole pipeline holds
// every word in place and pose.ready drops; bubbles do not close up.
// Reset clears all valid bits and loads the register defaults
// (unity scale factors, zero offset and zero bed slopes).
// ----------------------------------------------------------------------------
module cable_robot_step_kinematics_core (
	input  logic clk,
	input  logic arst_n,
	crsk_pose_if.sink   pose,
	crsk_step_if.source steps,
	crsk_cfg_if.sink    cfg
);
	import crsk_pkg::*;

	// configuration registers
	logic [31:0] spl_q;
	s32_t        spa_q;
	s32_t        zoff_q;
	s32_t        slope_x_q;
	s32_t        slope_y_q;
	s32_t        slope_ya_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spl_q      <= 32'd65536;
			spa_q      <= 32'sd65536;
			zoff_q     <= '0;
			slope_x_q  <= '0;
			slope_y_q  <= '0;
			slope_ya_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_STEPS_PER_LENGTH: spl_q      <= cfg.data;
				REG_STEPS_PER_ANGLE:  spa_q      <= cfg.data;
				REG_ZERO_OFFSET:      zoff_q     <= cfg.data;
				REG_SLOPE_X:          slope_x_q  <= cfg.data;
				REG_SLOPE_Y:          slope_y_q  <= cfg.data;
				REG_SLOPE_Y_ABS:      slope_ya_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline advance: move when the output register is empty or taken
	logic v_s8;
	logic en;
	assign en         = ~v_s8 | steps.ready;
	assign pose.ready = en;

	// stage 1: slope and rotation products
	logic               v_s1;
	s32_t               px_s1, py_s1, pz_s1;
	logic               mag_s1;
	logic signed [63:0] prod_x_s1, prod_y_s1, rot_prod_s1;
	logic signed [64:0] prod_ya_s1;
	logic signed [32:0] ay;

	assign ay = pose.pos_y[31] ? -33'(pose.pos_y) : 33'(pose.pos_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pose.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1       <= pose.pos_x;
			py_s1       <= pose.pos_y;
			pz_s1       <= pose.pos_z;
			mag_s1      <= pose.magnet_in;
			prod_x_s1   <= 64'(slope_x_q) * 64'(pose.pos_x);
			prod_y_s1   <= 64'(slope_y_q) * 64'(pose.pos_y);
			prod_ya_s1  <= 65'(slope_ya_q) * 65'(ay);
			rot_prod_s1 <= 64'(pose.angle) * 64'(spa_q);
		end
	end

	// stage 2: truncate products toward zero, finish rotation
	logic               v_s2;
	s32_t               px_s2, py_s2, pz_s2;
	side_t              side_s2;
	logic signed [64:0] tx_s2, ty_s2, tya_s2;
	logic signed [63:0] rot_q;

	always_comb begin
		rot_q = (rot_prod_s1 + (rot_prod_s1[63] ? 64'((64'sd1 <<< (2 * FRAC_BITS)) - 1)
			: 64'sd0)) >>> (2 * FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2       <= px_s1;
			py_s2       <= py_s1;
			pz_s2       <= pz_s1;
			tx_s2       <= tdiv_frac(65'(prod_x_s1));
			ty_s2       <= tdiv_frac(65'(prod_y_s1));
			tya_s2      <= tdiv_frac(prod_ya_s1);
			side_s2.rot <= sat32(67'(rot_q));
			side_s2.mag <= mag_s1;
		end
	end

	// stage 3: corrected bed height
	logic  v_s3;
	s32_t  px_s3, py_s3, nz_s3;
	side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s3   <= px_s2;
			py_s3   <= py_s2;
			nz_s3   <= sat32(67'(pz_s2) + 67'(tx_s2) + 67'(ty_s2) + 67'(tya_s2));
			side_s3 <= side_s2;
		end
	end

	// stage 4: saturated axis distances per cable
	logic        v_s4;
	side_t       side_s4;
	logic [30:0] dx_s4 [NUM_CABLES];
	logic [30:0] dy_s4 [NUM_CABLES];
	logic [30:0] dz_s4 [NUM_CABLES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			for (int k = 0; k < NUM_CABLES; k++) begin
				dx_s4[k] <= mag_sat(33'(ANCHOR_X[k]) - 33'(px_s3));
				dy_s4[k] <= mag_sat(33'(ANCHOR_Y[k]) - 33'(py_s3));
				dz_s4[k] <= mag_sat(33'(ANCHOR_Z[k]) - 33'(nz_s3));
			end
		end
	end

	// stage 5: squares
	logic        v_s5;
	side_t       side_s5;
	logic [61:0] sqx_s5 [NUM_CABLES];
	logic [61:0] sqy_s5 [NUM_CABLES];
	logic [61:0] sqz_s5 [NUM_CABLES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			for (int k = 0; k < NUM_CABLES; k++) begin
				sqx_s5[k] <= 62'(dx_s4[k]) * 62'(dx_s4[k]);
				sqy_s5[k] <= 62'(dy_s4[k]) * 62'(dy_s4[k]);
				sqz_s5[k] <= 62'(dz_s4[k]) * 62'(dz_s4[k]);
			end
		end
	end

	// stage 6: sum of squares, feeds the root pipeline
	logic        v_s6;
	side_t       side_s6;
	logic [63:0] sum_s6 [NUM_CABLES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= side_s5;
			for (int k = 0; k < NUM_CABLES; k++) begin
				sum_s6[k] <= 64'(sqx_s5[k]) + 64'(sqy_s5[k]) + 64'(sqz_s5[k]);
			end
		end
	end

	// square root: one restoring step per stage, one root bit each
	logic        sq_v    [SQ_STEPS+1];
	side_t       sq_side [SQ_STEPS+1];
	logic [63:0] sq_rad  [SQ_STEPS+1][NUM_CABLES];
	logic [33:0] sq_rem  [SQ_STEPS+1][NUM_CABLES];
	logic [31:0] sq_root [SQ_STEPS+1][NUM_CABLES];

	assign sq_v[0]    = v_s6;
	assign sq_side[0] = side_s6;
	for (genvar k = 0; k < NUM_CABLES; k++) begin : g_sq_in
		assign sq_rad[0][k]  = sum_s6[k];
		assign sq_rem[0][k]  = '0;
		assign sq_root[0][k] = '0;
	end

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[i+1] <= 1'b0;
			end else if (en) begin
				sq_v[i+1] <= sq_v[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_side[i+1] <= sq_side[i];
			end
		end

		for (genvar k = 0; k < NUM_CABLES; k++) begin : g_lane
			logic [35:0] pre;
			logic [35:0] trial;
			assign pre   = {sq_rem[i][k], sq_rad[i][k][63-2*i -: 2]};
			assign trial = 36'({sq_root[i][k], 2'b01});

			always_ff @(posedge clk) begin
				if (en) begin
					sq_rad[i+1][k] <= sq_rad[i][k];
					if (pre >= trial) begin
						sq_rem[i+1][k]  <= 34'(pre - trial);
						sq_root[i+1][k] <= {sq_root[i][k][30:0], 1'b1};
					end else begin
						sq_rem[i+1][k]  <= pre[33:0];
						sq_root[i+1][k] <= {sq_root[i][k][30:0], 1'b0};
					end
				end
			end
		end
	end

	// stage 7: distance times steps per length
	logic        v_s7;
	side_t       side_s7;
	logic [63:0] lprod_s7 [NUM_CABLES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= sq_v[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= sq_side[SQ_STEPS];
			for (int k = 0; k < NUM_CABLES; k++) begin
				lprod_s7[k] <= 64'(sq_root[SQ_STEPS][k]) * 64'(spl_q);
			end
		end
	end

	// stage 8: drop fraction, clamp, apply zero offset, saturate
	s32_t cab_w [NUM_CABLES];

	always_comb begin
		logic [63:0]        whole;
		logic [33:0]        clamped;
		logic signed [35:0] diff;
		for (int k = 0; k < NUM_CABLES; k++) begin
			whole   = lprod_s7[k] >> (2 * FRAC_BITS);
			clamped = (whole > STEP_CLAMP) ? STEP_CLAMP[33:0] : whole[33:0];
			diff    = $signed({2'b00, clamped}) - 36'(zoff_q);
			cab_w[k] = sat32(67'(diff));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			steps.cable0_steps   <= cab_w[0];
			steps.cable1_steps   <= cab_w[1];
			steps.cable2_steps   <= cab_w[2];
			steps.rotation_steps <= side_s7.rot;
			steps.magnet_out     <= side_s7.mag;
		end
	end

	assign steps.valid = v_s8;

endmodule
